### hw/rtl/antialiased_vector_line_rasterizer_assert.svh
// Assertion macros shared by the rasterizer modules.
`ifndef ANTIALIASED_VECTOR_LINE_RASTERIZER_ASSERT_SVH
`define ANTIALIASED_VECTOR_LINE_RASTERIZER_ASSERT_SVH

// An implication checked on every clock edge outside reset.
`define AVLR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// A next-cycle implication checked outside reset.
`define AVLR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/avlr_pkg.sv
`timescale 1ns / 1ps
package avlr_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] seg_x0;
    logic signed [15:0] seg_y0;
    logic signed [15:0] seg_x1;
    logic signed [15:0] seg_y1;
    logic [2:0]         seg_hue;
    logic [4:0]         seg_brightness;
    logic [7:0]         read_col;
    logic [8:0]         read_row;
  } avlr_in_t;

  typedef struct packed {
    logic       read_valid;
    logic [2:0] pixel_hue;
    logic [4:0] pixel_brightness;
  } avlr_out_t;

  localparam int unsigned LumMax = 31;

  // Requests from the sequencer to the frame store port.
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [7:0] data;
  } avlr_mem_req_t;

endpackage

### hw/rtl/avlr_div.sv
`timescale 1ns / 1ps
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module avlr_div
  import avlr_pkg::*;
#(
  parameter int unsigned W = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic                done_o,
  output logic signed [W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic          neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;
  logic [W-1:0]  an, ad;

  assign an = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign ad = den_i[W-1] ? W'(-den_i) : W'(den_i);
  assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (go_i) begin
      rem_d  = '0;
      quo_d  = an;
      den_d  = ad;
      neg_d  = num_i[W-1] ^ den_i[W-1];
      busy_d = 1'b1;
      cnt_d  = CW'(W);
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? W'(-quo_q) : W'(quo_q);

endmodule

### hw/rtl/avlr_store.sv
`timescale 1ns / 1ps
// Frame store: one write and one read port, read data registered.
module avlr_store
  import avlr_pkg::*;
#(
  parameter int unsigned DEPTH = 67200,
  parameter int unsigned AW    = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  avlr_mem_req_t req_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic       rd_seen_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[wr_addr_i] <= req_i.data;
    end
    if (req_i.rd) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_seen_q <= 1'b0;
    end else begin
      rd_seen_q <= req_i.rd;
    end
  end

  `include "antialiased_vector_line_rasterizer_assert.svh"
  `AVLR_ASSERT_IMP(a_wr_in_range, clk_i, rst_ni, req_i.wr, wr_addr_i < AW'(DEPTH))
  `AVLR_ASSERT_IMP(a_rd_in_range, clk_i, rst_ni, req_i.rd, rd_addr_i < AW'(DEPTH))
  `AVLR_ASSERT_NXT(a_rd_seen, clk_i, rst_ni, req_i.rd, rd_seen_q)

endmodule

### hw/rtl/antialiased_vector_line_rasterizer.sv
`timescale 1ns / 1ps
// Antialiased line rasterizer over a byte-per-pixel frame store in one memory.
// Transfer an item by raising start while busy is low; exactly one result
// strobe follows per item and must be taken in that cycle, as the receiver
// cannot stall. After reset, and after each clear item, the block sweeps the
// store one pixel a cycle with busy high; a clear item's strobe comes in the
// cycle after its transfer. A read inside the panel holds busy through S_RD0
// and S_RD1 and then strobes; a read outside it strobes with read_valid low.
// A draw scales the four endpoint coordinates (S_MAP, S_MAPW and S_MAPA for
// each), sets up in S_SETUP and waits in S_SLOPE on the serial slope divide.
// Each major-axis step inside the panel then passes S_STEP and S_PIX for each
// of its two pixels; a pixel that is written also passes S_PRD (read), S_DONE
// (wait) and S_PBL (blend and write). A draw whose endpoints map to one pixel
// skips the divide and blends only that pixel, if it lies in the panel.
module antialiased_vector_line_rasterizer
  import avlr_pkg::*;
#(
  parameter int unsigned PANEL_COLS  = 240,
  parameter int unsigned PANEL_ROWS  = 280,
  parameter int unsigned BEAM_WIDTH  = 570,
  parameter int unsigned BEAM_HEIGHT = 580
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  avlr_in_t  item_i,
  output logic      busy,
  output logic      strobe,
  output avlr_out_t result_o
);

  localparam int unsigned PixCount = PANEL_COLS * PANEL_ROWS;
  localparam int unsigned AW       = $clog2(PixCount);
  localparam int unsigned PicH     = (PANEL_COLS * BEAM_HEIGHT) / BEAM_WIDTH;
  localparam int          Top      = (int'(PANEL_ROWS) - int'(PicH)) / 2;
  localparam int unsigned DW       = 50;
  localparam int          ColMax   = int'(PANEL_COLS) - 1;
  localparam int          RowMax   = int'(PANEL_ROWS) - 1;
  // Endpoint scaling divides by the beam size through a rounded-up reciprocal,
  // which is exact while the scaled magnitude stays below 2^NW.
  localparam int unsigned XK = PANEL_COLS - 1;
  localparam int unsigned YK = PicH - 1;
  localparam int unsigned KW = $clog2(((XK > YK) ? XK : YK) + 1);
  localparam int unsigned NW = 16 + KW;
  localparam int unsigned MW = NW + 1;
  localparam int unsigned PW = NW + MW;
  localparam int unsigned XS = NW + $clog2(BEAM_WIDTH);
  localparam int unsigned YS = NW + $clog2(BEAM_HEIGHT);
  localparam longint unsigned XM = ((64'd1 << XS) + BEAM_WIDTH - 1) / BEAM_WIDTH;
  localparam longint unsigned YM = ((64'd1 << YS) + BEAM_HEIGHT - 1) / BEAM_HEIGHT;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD0, S_RD1, S_MAP, S_MAPW, S_MAPA, S_SETUP, S_SLOPE, S_STEP,
    S_PIX, S_PRD, S_PBL, S_DONE, S_POINT
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     clr_q;
  avlr_in_t          it_q;
  logic [1:0]        mi_q;
  logic signed [31:0] c_q [4];
  logic [NW-1:0]     mag_q, mq_q;
  logic              mneg_q;
  logic signed [31:0] m0_q, n0_q, m1_q, m_q, hi_q;
  logic signed [DW-1:0] step_q, acc_q;
  logic              xmaj_q, side_q;
  logic [4:0]        w_q;
  logic [AW-1:0]     addr_q;
  avlr_out_t         res_q;
  logic              strobe_q;

  logic              dgo;
  logic signed [DW-1:0] dnum, dden, dquo;
  logic              ddone;
  avlr_mem_req_t     mreq;
  logic [7:0]        rdata;

  avlr_div #(.W(DW)) u_div (
    .clk_i, .rst_ni, .go_i(dgo), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  avlr_store #(.DEPTH(PixCount), .AW(AW)) u_store (
    .clk_i, .rst_ni, .req_i(mreq), .rd_addr_i(addr_q),
    .wr_addr_i(state_q == S_CLEAR ? clr_q : addr_q), .rd_data_o(rdata)
  );

  // Mapping operands for coordinate mi_q: 0 x0, 1 y0, 2 x1, 3 y1.
  logic signed [15:0] mcoord;
  always_comb begin
    unique case (mi_q)
      2'd0:    mcoord = it_q.seg_x0;
      2'd1:    mcoord = it_q.seg_y0;
      2'd2:    mcoord = it_q.seg_x1;
      default: mcoord = it_q.seg_y1;
    endcase
  end

  logic [15:0]        mabs;
  logic [MW-1:0]      rmul;
  logic [PW-1:0]      rprod;
  logic signed [31:0] mval;
  assign mabs  = mcoord[15] ? 16'(-mcoord) : 16'(mcoord);
  assign rmul  = mi_q[0] ? MW'(YM) : MW'(XM);
  assign rprod = PW'(mag_q) * PW'(rmul);
  assign mval  = mneg_q ? -$signed(32'(mq_q)) : $signed(32'(mq_q));

  logic signed [31:0] dx, dy, adx, ady;
  assign dx  = c_q[2] - c_q[0];
  assign dy  = c_q[3] - c_q[1];
  assign adx = dx[31] ? -dx : dx;
  assign ady = dy[31] ? -dy : dy;

  logic signed [31:0] dmin, dmaj;
  assign dmin = (adx >= ady) ? (dx[31] ? -dy : dy) : (dy[31] ? -dx : dx);
  assign dmaj = (adx >= ady) ? adx : ady;

  logic signed [31:0]   moff;
  logic signed [17:0]   step_s;
  logic signed [DW-1:0] sprod;
  assign moff   = m_q - m0_q;
  assign step_s = $signed(step_q[17:0]);
  assign sprod  = moff * step_s;

  logic signed [31:0] ni;
  logic [7:0]         frac;
  logic [12:0]        w0p, w1p;
  assign ni   = 32'(acc_q >>> 16);
  assign frac = acc_q[15:8];
  assign w0p  = it_q.seg_brightness * (9'd256 - {1'b0, frac});
  assign w1p  = it_q.seg_brightness * frac;

  logic signed [31:0] tx, ty;
  logic [4:0]         tw;
  always_comb begin
    tw = side_q ? w1p[12:8] : w0p[12:8];
    if (xmaj_q) begin
      tx = m_q;
      ty = side_q ? ni + 1 : ni;
    end else begin
      ty = m_q;
      tx = side_q ? ni + 1 : ni;
    end
  end

  logic       tin;
  assign tin = (tx >= 0) && (tx < 32'(PANEL_COLS)) && (ty >= 0) && (ty < 32'(PANEL_ROWS));

  logic tin_pt;
  assign tin_pt = (c_q[0] >= 0) && (c_q[0] < 32'(PANEL_COLS)) &&
                  (c_q[1] >= 0) && (c_q[1] < 32'(PANEL_ROWS));

  logic [2:0] oh;
  logic [4:0] ob;
  logic [5:0] sum;
  logic [7:0] bl;
  assign oh  = rdata[7:5];
  assign ob  = rdata[4:0];
  assign sum = {1'b0, ob} + {1'b0, w_q};
  always_comb begin
    priority if (ob == '0) begin
      bl = {it_q.seg_hue, w_q};
    end else if (oh == it_q.seg_hue) begin
      bl = {it_q.seg_hue, sum > 6'(LumMax) ? 5'(LumMax) : sum[4:0]};
    end else if (w_q > ob) begin
      bl = {it_q.seg_hue, w_q};
    end else begin
      bl = rdata;
    end
  end

  // The slope divide is the only use of the serial divider.
  assign dgo  = state_q == S_SETUP;
  assign dnum = DW'(dmin) <<< 16;
  assign dden = DW'(dmaj);

  always_comb begin
    mreq.wr   = (state_q == S_CLEAR) || (state_q == S_PBL);
    mreq.rd   = (state_q == S_PRD) || (state_q == S_RD0);
    mreq.data = (state_q == S_CLEAR) ? 8'h00 : bl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      strobe_q <= 1'b0;
      res_q    <= '0;
      mi_q     <= '0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(PixCount - 1)) begin
            clr_q <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          res_q <= '0;
          if (start) begin
            it_q <= item_i;
            unique case (op_e'(item_i.op))
              OP_CLEAR: begin
                strobe_q <= 1'b1;
                state_q  <= S_CLEAR;
              end
              OP_DRAW: begin
                mi_q    <= '0;
                state_q <= S_MAP;
              end
              OP_READ: begin
                if (32'(item_i.read_col) < 32'(PANEL_COLS) &&
                    32'(item_i.read_row) < 32'(PANEL_ROWS)) begin
                  addr_q  <= AW'(32'(item_i.read_row) * PANEL_COLS + 32'(item_i.read_col));
                  state_q <= S_RD0;
                end else begin
                  strobe_q <= 1'b1;
                end
              end
              default: strobe_q <= 1'b1;
            endcase
          end
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: begin
          res_q    <= '{read_valid: 1'b1, pixel_hue: rdata[7:5], pixel_brightness: rdata[4:0]};
          strobe_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_MAP: begin
          mag_q   <= NW'(mabs) * NW'(mi_q[0] ? YK : XK);
          mneg_q  <= mcoord[15];
          state_q <= S_MAPW;
        end
        S_MAPW: begin
          mq_q    <= mi_q[0] ? NW'(rprod >> YS) : NW'(rprod >> XS);
          state_q <= S_MAPA;
        end
        S_MAPA: begin
          c_q[mi_q] <= mi_q[0] ? mval + 32'(Top) : mval;
          mi_q      <= mi_q + 1'b1;
          state_q   <= (mi_q == 2'd3) ? S_SETUP : S_MAP;
        end
        S_SETUP: begin
          if (adx == 0 && ady == 0) begin
            xmaj_q  <= 1'b1;
            state_q <= S_POINT;
          end else begin
            xmaj_q <= adx >= ady;
            if (adx >= ady) begin
              m0_q <= dx[31] ? c_q[2] : c_q[0];
              n0_q <= dx[31] ? c_q[3] : c_q[1];
              m1_q <= dx[31] ? c_q[0] : c_q[2];
            end else begin
              m0_q <= dy[31] ? c_q[3] : c_q[1];
              n0_q <= dy[31] ? c_q[2] : c_q[0];
              m1_q <= dy[31] ? c_q[1] : c_q[3];
            end
            state_q <= S_SLOPE;
          end
        end
        S_POINT: begin
          if (tin_pt && it_q.seg_brightness != '0) begin
            addr_q  <= AW'(c_q[1] * PANEL_COLS + c_q[0]);
            w_q     <= it_q.seg_brightness;
            state_q <= S_PRD;
            side_q  <= 1'b1;
            hi_q    <= -32'sd1;
            m_q     <= 32'sd0;
          end else begin
            strobe_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_SLOPE: begin
          if (ddone) begin
            step_q <= dquo;
            m_q    <= m0_q < 0 ? 32'sd0 : m0_q;
            hi_q   <= m1_q > (xmaj_q ? 32'(ColMax) : 32'(RowMax))
                      ? (xmaj_q ? 32'(ColMax) : 32'(RowMax)) : m1_q;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (m_q > hi_q) begin
            strobe_q <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            acc_q   <= (DW'(n0_q) <<< 16) + sprod;
            side_q  <= 1'b0;
            state_q <= S_PIX;
          end
        end
        S_PIX: begin
          if (tin && tw != '0) begin
            addr_q  <= AW'(ty * PANEL_COLS + tx);
            w_q     <= tw;
            state_q <= S_PRD;
          end else if (!side_q) begin
            side_q <= 1'b1;
          end else begin
            m_q     <= m_q + 1;
            state_q <= S_STEP;
          end
        end
        S_PRD: state_q <= S_DONE;
        S_DONE: state_q <= S_PBL;
        S_PBL: begin
          if (!side_q) begin
            side_q  <= 1'b1;
            state_q <= S_PIX;
          end else begin
            m_q     <= m_q + 1;
            state_q <= S_STEP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy     = state_q != S_IDLE;
  assign strobe   = strobe_q;
  assign result_o = res_q;

  `include "antialiased_vector_line_rasterizer_assert.svh"
  `AVLR_ASSERT_IMP(a_wr_busy, clk_i, rst_ni, mreq.wr, busy)
  `AVLR_ASSERT_NXT(a_take_busy, clk_i, rst_ni, start && !busy && item_i.op == OP_DRAW, busy)
  `AVLR_ASSERT_IMP(a_valid_strobe, clk_i, rst_ni, result_o.read_valid && strobe, !busy)

endmodule
